@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WWR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WWR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/wwr_pkg.sv @@
package wwr_pkg;

    localparam int WORD_BYTES_DEF = 8;
    localparam int MAX_WORD_LEN   = 8;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 4;
    localparam int WORD_W         = MAX_WORD_LEN * BYTE_W;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WORD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEN    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_WORD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN  = 8'd3;

    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PERIOD  = 8'h2E;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] tail;
    } wwr_job_t;

    typedef struct packed {
        logic     push;
        wwr_job_t job;
    } wwr_push_t;

    typedef struct packed {
        logic             pop;
        logic [LEN_W-1:0] idx;
    } wwr_back_stat_t;

    function automatic logic is_delim(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_COMMA) || (b == CH_NEWLINE) || (b == CH_PERIOD);
    endfunction

endpackage

@@ design/wwr_in_if.sv @@
interface wwr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

@@ design/wwr_out_if.sv @@
interface wwr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

@@ design/wwr_cfg_if.sv @@
interface wwr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/wwr_front.sv @@
module wwr_front #(
    parameter int WORD_BYTES = wwr_pkg::WORD_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    wwr_in_if.sink            text,
    wwr_cfg_if.sink           cfg,
    input  logic              q_full,
    output wwr_pkg::wwr_push_t push
);
    import wwr_pkg::*;

    localparam int IDX_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam logic [LEN_W-1:0] FULL_CNT = LEN_W'(WORD_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_WORD_LEN);

    logic [BYTE_W-1:0] store_reg [WORD_BYTES];
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              long_reg, long_next;

    logic [WORD_W-1:0] match_word_reg;
    logic [LEN_W-1:0]  match_len_reg;
    logic [WORD_W-1:0] replace_word_reg;
    logic [LEN_W-1:0]  replace_len_reg;

    logic              acc;
    logic              delim;
    logic              do_store;
    logic              hit;
    logic [WORD_W-1:0] store_word;
    logic [LEN_W-1:0]  rep_len;

    assign text.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign acc        = text.valid && text.ready;
    assign delim      = is_delim(text.in_byte);
    assign do_store   = acc && !delim && !long_reg && (count_reg < FULL_CNT);
    assign rep_len    = (replace_len_reg > MAX_LEN) ? MAX_LEN : replace_len_reg;

    always_comb
    begin
        store_word = '0;
        hit        = (match_len_reg == count_reg);
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            store_word[i*BYTE_W +: BYTE_W] = store_reg[i];
            if ((LEN_W'(i) < count_reg) &&
                (store_reg[i] != match_word_reg[i*BYTE_W +: BYTE_W]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        push          = '0;
        push.job.tail = text.in_byte;
        count_next    = count_reg;
        long_next     = long_reg;
        if (acc)
        begin
            if (!delim)
            begin
                if (long_reg)
                begin
                    push.push = 1'b1;
                end
                else if (count_reg < FULL_CNT)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    push.push     = 1'b1;
                    push.job.word = store_word;
                    push.job.len  = FULL_CNT;
                    count_next    = '0;
                    long_next     = 1'b1;
                end
            end
            else
            begin
                push.push = 1'b1;
                if (!long_reg)
                begin
                    if (hit)
                    begin
                        push.job.word = replace_word_reg;
                        push.job.len  = rep_len;
                    end
                    else
                    begin
                        push.job.word = store_word;
                        push.job.len  = count_reg;
                    end
                end
                count_next = '0;
                long_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= text.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            long_reg         <= 1'b0;
            match_word_reg   <= '0;
            match_len_reg    <= '0;
            replace_word_reg <= '0;
            replace_len_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            long_reg  <= long_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_MATCH_WORD:   match_word_reg   <= cfg.data;
                    REG_MATCH_LEN:    match_len_reg    <= cfg.data[LEN_W-1:0];
                    REG_REPLACE_WORD: replace_word_reg <= cfg.data;
                    REG_REPLACE_LEN:  replace_len_reg  <= cfg.data[LEN_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

@@ design/wwr_queue.sv @@
module wwr_queue #(
    parameter int DEPTH = wwr_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wwr_pkg::wwr_push_t  push,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output wwr_pkg::wwr_job_t   head
);
    import wwr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    wwr_job_t           job_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = job_reg[rd_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_reg[wr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/wwr_back.sv @@
module wwr_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  wwr_pkg::wwr_job_t        head,
    output wwr_pkg::wwr_back_stat_t  stat,
    wwr_out_if.source                result
);
    import wwr_pkg::*;

    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              last;
    logic [BYTE_W-1:0] word_byte;

    assign last      = (idx_reg >= head.len);
    assign word_byte = BYTE_W'(head.word >> {idx_reg[2:0], 3'b000});

    assign result.valid    = head_valid;
    assign result.out_byte = last ? head.tail : word_byte;
    assign result.run_last = last;

    assign stat.pop = head_valid && result.ready && last;
    assign stat.idx = idx_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (head_valid && result.ready)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ design/whole_word_replace_stream.sv @@
// Channel  | Role  | Payload               | Transaction
// ---------+-------+-----------------------+-------------------------------
// text     | sink  | in_byte               | one input byte
// result   | src   | out_byte, run_last    | one output byte
// cfg      | sink  | index, data           | one register write
//
// Accepts one text byte per cycle while the job queue has room.
// A trigger byte queues a job; its first byte is offered once it heads the queue.
// A delimiter, or a byte that overflows the word buffer, produces up to
// MAX_WORD_LEN + 1 output bytes, one per cycle; the result port sets the output rate.
// Reset clears word count, overflow flag, queue and registers; no clearing pass.
// A stalled result fills the two-entry job queue, then text.ready drops.
`include "assert_macros.svh"

module whole_word_replace_stream #(
    parameter int WORD_BYTES = wwr_pkg::WORD_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wwr_in_if.sink    text,
    wwr_out_if.source result,
    wwr_cfg_if.sink   cfg
);
    import wwr_pkg::*;

    wwr_push_t      push;
    wwr_job_t       head;
    wwr_back_stat_t back_stat;
    logic           q_full;
    logic           head_valid;
    logic           run_done;

    assign run_done = result.valid && result.ready && result.run_last;

    wwr_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push)
    );

    wwr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (back_stat.pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    wwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .stat       (back_stat),
        .result     (result)
    );

    `WWR_ASSERT_IMPL(a_push_not_full, push.push, !q_full)
    `WWR_ASSERT_IMPL(a_idx_bounded, head_valid, back_stat.idx <= head.len)
    `WWR_ASSERT_IMPL(a_len_range, head_valid, head.len <= LEN_W'(MAX_WORD_LEN))
    `WWR_ASSERT_NEXT(a_last_clears_idx, run_done, back_stat.idx == '0)

endmodule
